FILE: design/rss_pkg.sv
// Shared types and codes for the random sample set.
// No dependencies; imported by every design file.
`timescale 1ns / 1ps

package rss_pkg;

  localparam int VALUE_W = 32;
  localparam int RAND_W  = 16;
  localparam int OP_W    = 2;
  localparam int STAT_W  = 2;

  typedef logic [OP_W-1:0]   op_t;
  typedef logic [STAT_W-1:0] status_t;

  localparam op_t OP_INSERT = 2'd0;
  localparam op_t OP_REMOVE = 2'd1;
  localparam op_t OP_SAMPLE = 2'd2;

  localparam status_t ST_DONE     = 2'd0;
  localparam status_t ST_PRESENCE = 2'd1;
  localparam status_t ST_FULL     = 2'd2;
  localparam status_t ST_EMPTY    = 2'd3;

endpackage

FILE: design/rss_mod_unit.sv
// Iterative remainder unit: one restoring step per cycle over the random word.
// Depends on rss_pkg.
`timescale 1ns / 1ps

module rss_mod_unit import rss_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [RAND_W-1:0]                 dividend,
  input  logic [$clog2(CAPACITY+1)-1:0]     divisor,
  output logic                              done,
  output logic [$clog2(CAPACITY)-1:0]       remainder
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);
  localparam int SW = $clog2(RAND_W);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [SW-1:0]     step_r, step_nxt;
  logic [RAND_W-1:0] dvd_r, dvd_nxt;
  logic [CW-1:0]     dsr_r, dsr_nxt;
  logic [CW-1:0]     rem_r, rem_nxt;
  logic [CW:0]       trial;

  assign trial = {rem_r, dvd_r[RAND_W-1]};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    dvd_nxt  = dvd_r;
    dsr_nxt  = dsr_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      dvd_nxt  = dividend;
      dsr_nxt  = divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[RAND_W-2:0], 1'b0};
      if (trial >= {1'b0, dsr_r}) begin
        rem_nxt = CW'(trial - {1'b0, dsr_r});
      end else begin
        rem_nxt = CW'(trial);
      end
      step_nxt = step_r + 1'b1;
      if (step_r == SW'(RAND_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
    rem_r <= rem_nxt;
  end

  assign done      = done_r;
  assign remainder = rem_r[IW-1:0];

endmodule

FILE: design/rss_store.sv
// Member array: one write port and one registered read port.
// Depends on rss_pkg.
`timescale 1ns / 1ps

module rss_store import rss_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic                          clk,
  input  logic                          rd_en,
  input  logic [$clog2(CAPACITY)-1:0]   rd_addr,
  output logic [VALUE_W-1:0]            rd_data,
  input  logic                          wr_en,
  input  logic [$clog2(CAPACITY)-1:0]   wr_addr,
  input  logic [VALUE_W-1:0]            wr_data
);

  logic [VALUE_W-1:0] mem [CAPACITY];
  logic [VALUE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: design/random_sample_set_top.sv
// Random sample set: a set of distinct 32-bit values with insert, remove
// and random sample.
// Input channel: in_valid / in_stall with in_operation, in_value and
// in_random_word; one item is taken per transfer when the block is idle.
// Result channel: out_valid / out_stall with out_status and
// out_picked_value; exactly one result per input item, in order.
// Insert and remove scan the member array one entry per cycle through the
// array's single read port. Sample runs the 16-step remainder unit, one bit
// per cycle, then one array read. Operation code 3 and a sample of an empty
// set go straight to the result.
// in_stall is high while an item is in work; the next item is taken once
// its result sits in the output register, even if that result is stalled.
// A stalled result holds in the output register; a finished item waits in
// its last step until the register frees.
// Synchronous reset empties the set and drops any result in flight; the
// array contents need no clearing.
// Depends on rss_pkg, rss_store and rss_mod_unit.
`timescale 1ns / 1ps

module random_sample_set_top import rss_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [OP_W-1:0]           in_operation,
  input  logic signed [VALUE_W-1:0] in_value,
  input  logic [RAND_W-1:0]         in_random_word,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [STAT_W-1:0]         out_status,
  output logic signed [VALUE_W-1:0] out_picked_value
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_SCAN     = 3'd1;
  localparam logic [2:0] S_MOD      = 3'd2;
  localparam logic [2:0] S_PICK_GET = 3'd3;
  localparam logic [2:0] S_MOVE_RD  = 3'd4;
  localparam logic [2:0] S_MOVE_WR  = 3'd5;
  localparam logic [2:0] S_RESULT   = 3'd6;

  logic [2:0]         state_r, state_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [CW-1:0]      scan_r, scan_nxt;
  logic               cmp_vld_r, cmp_vld_nxt;
  logic [IW-1:0]      cmp_idx_r, cmp_idx_nxt;
  logic [IW-1:0]      hit_idx_r, hit_idx_nxt;
  op_t                op_r, op_nxt;
  logic [VALUE_W-1:0] value_r, value_nxt;
  status_t            res_status_r, res_status_nxt;
  logic [VALUE_W-1:0] res_picked_r, res_picked_nxt;
  logic               out_valid_r, out_valid_nxt;
  status_t            out_status_r, out_status_nxt;
  logic [VALUE_W-1:0] out_picked_r, out_picked_nxt;

  logic               rd_en;
  logic [IW-1:0]      rd_addr;
  logic [VALUE_W-1:0] rd_data;
  logic               wr_en;
  logic [IW-1:0]      wr_addr;
  logic [VALUE_W-1:0] wr_data;
  logic               mod_start;
  logic               mod_done;
  logic [IW-1:0]      mod_rem;
  logic [CW-1:0]      last_pos;
  logic               in_xfer;
  logic               out_load;

  assign in_xfer  = in_valid && (state_r == S_IDLE);
  assign out_load = (state_r == S_RESULT) && (!out_valid_r || !out_stall);
  assign last_pos = count_r - 1'b1;

  rss_store #(.CAPACITY(CAPACITY)) u_store (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  rss_mod_unit #(.CAPACITY(CAPACITY)) u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (mod_start),
    .dividend  (in_random_word),
    .divisor   (count_r),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    scan_nxt       = scan_r;
    cmp_vld_nxt    = cmp_vld_r;
    cmp_idx_nxt    = cmp_idx_r;
    hit_idx_nxt    = hit_idx_r;
    op_nxt         = op_r;
    value_nxt      = value_r;
    res_status_nxt = res_status_r;
    res_picked_nxt = res_picked_r;
    rd_en          = 1'b0;
    rd_addr        = scan_r[IW-1:0];
    wr_en          = 1'b0;
    wr_addr        = count_r[IW-1:0];
    wr_data        = value_r;
    mod_start      = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          op_nxt         = in_operation;
          value_nxt      = in_value;
          scan_nxt       = '0;
          cmp_vld_nxt    = 1'b0;
          res_status_nxt = ST_DONE;
          res_picked_nxt = '0;
          case (in_operation)
            OP_INSERT, OP_REMOVE: begin
              state_nxt = S_SCAN;
            end
            OP_SAMPLE: begin
              if (count_r == '0) begin
                res_status_nxt = ST_EMPTY;
                state_nxt      = S_RESULT;
              end else begin
                mod_start = 1'b1;
                state_nxt = S_MOD;
              end
            end
            default: begin
              state_nxt = S_RESULT;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (cmp_vld_r && (rd_data == value_r)) begin
          hit_idx_nxt = cmp_idx_r;
          if (op_r == OP_INSERT) begin
            res_status_nxt = ST_PRESENCE;
            state_nxt      = S_RESULT;
          end else begin
            state_nxt = S_MOVE_RD;
          end
        end else if (scan_r != count_r) begin
          rd_en       = 1'b1;
          rd_addr     = scan_r[IW-1:0];
          scan_nxt    = scan_r + 1'b1;
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = scan_r[IW-1:0];
        end else begin
          state_nxt = S_RESULT;
          if (op_r == OP_INSERT) begin
            if (count_r == CW'(CAPACITY)) begin
              res_status_nxt = ST_FULL;
            end else begin
              wr_en     = 1'b1;
              wr_addr   = count_r[IW-1:0];
              wr_data   = value_r;
              count_nxt = count_r + 1'b1;
            end
          end else begin
            res_status_nxt = ST_PRESENCE;
          end
        end
      end
      S_MOD: begin
        if (mod_done) begin
          rd_en     = 1'b1;
          rd_addr   = mod_rem;
          state_nxt = S_PICK_GET;
        end
      end
      S_PICK_GET: begin
        res_picked_nxt = rd_data;
        state_nxt      = S_RESULT;
      end
      S_MOVE_RD: begin
        rd_en     = 1'b1;
        rd_addr   = last_pos[IW-1:0];
        state_nxt = S_MOVE_WR;
      end
      S_MOVE_WR: begin
        wr_en     = 1'b1;
        wr_addr   = hit_idx_r;
        wr_data   = rd_data;
        count_nxt = last_pos;
        state_nxt = S_RESULT;
      end
      S_RESULT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_picked_nxt = out_picked_r;
    if (out_load) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = res_status_r;
      out_picked_nxt = res_picked_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    scan_r       <= scan_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    hit_idx_r    <= hit_idx_nxt;
    op_r         <= op_nxt;
    value_r      <= value_nxt;
    res_status_r <= res_status_nxt;
    res_picked_r <= res_picked_nxt;
    out_status_r <= out_status_nxt;
    out_picked_r <= out_picked_nxt;
  end

  assign in_stall         = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_picked_value = out_picked_r;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("member count above capacity");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (count_r == $past(count_r)) ||
                     (count_r == $past(count_r) + 1'b1) ||
                     (count_r == $past(count_r) - 1'b1))
    else $error("member count moved by more than one");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r != ST_DONE)) |-> (out_picked_r == '0))
    else $error("error result carries a nonzero value");

  a_write_owner: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> ((state_r == S_SCAN) && (op_r == OP_INSERT)) ||
              ((state_r == S_MOVE_WR) && (count_r != '0)))
    else $error("array write outside insert or remove");
`endif

endmodule
